// ===== hdl/csl_pkg.sv =====
`timescale 1ns / 1ps

package csl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int MAX_RESULTS       = 3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM1,
        MODE_DEC,
        MODE_DOT,
        MODE_FRAC,
        MODE_HEX,
        MODE_BIN,
        MODE_CHOPEN,
        MODE_CHCLOSE,
        MODE_STRING,
        MODE_ERROR
    } mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT,
        KIND_NUMBER,
        KIND_FLOAT,
        KIND_STRING,
        KIND_SEP,
        KIND_CHAR,
        KIND_ERROR,
        KIND_END
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } char_word_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] token_value;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_in_run;
    } token_word_t;

    function automatic token_word_t make_token(
        input kind_t       kind,
        input logic [31:0] value,
        input logic [15:0] start,
        input logic [15:0] length,
        input logic [15:0] line
    );
        token_word_t t;
        t.token_kind   = kind;
        t.token_value  = value;
        t.token_start  = start;
        t.token_length = length;
        t.line_number  = line;
        t.last_in_run  = 1'b0;
        return t;
    endfunction

endpackage

// ===== hdl/character_stream_lexer.sv =====
`timescale 1ns / 1ps

// Path: a character word enters the input register, is lexed from there, and its tokens
// are written to the result queue, whose head drives the token port.
// Throughput: one character word per cycle while at most one token queues; a word that
// gives several tokens fills the result queue, and lexing waits while more than one token queues.
// Reset (rst_n low, asynchronous) empties both registers and clears all lexer state.
module character_stream_lexer
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  char_word_t  char_word,
    output logic        token_valid,
    input  logic        token_stall,
    output token_word_t token_word
);

    localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POSITION_BITS-1:0] pos_t;

    function automatic pos_t sat_inc(input pos_t x);
        return (x == '1) ? x : x + pos_t'(1);
    endfunction

    function automatic logic [15:0] rep16(input pos_t x);
        logic [31:0] w;
        w = 32'(x);
        return w[15:0];
    endfunction

    // Input register
    char_word_t in_reg;
    logic       in_valid_reg;
    logic       process;

    // Lexer state
    mode_t       mode_reg, mode_next;
    logic [31:0] value_reg, value_next;
    pos_t        start_reg, start_next;
    pos_t        length_reg, length_next;
    pos_t        line_reg, line_next;
    pos_t        pos_reg, pos_next;
    logic [7:0]  first_reg, first_next;
    logic        esc_reg, esc_next;

    // Result queue, read at slot zero
    token_word_t q_reg [QUEUE_DEPTH];
    token_word_t q_next [QUEUE_DEPTH];
    logic [CountBits-1:0] count_reg, count_next;
    logic        pop;

    // Byte classification
    logic [7:0]  b;
    logic        eot;
    logic        is_digit, is_alpha, is_space, is_ident, is_hex, is_bit, is_single;
    logic [3:0]  hex_val;
    logic        close, restart;

    token_word_t res [MAX_RESULTS];
    logic [1:0]  res_count;

    assign b   = in_reg.text_byte;
    assign eot = in_reg.end_of_text;

    assign process    = in_valid_reg && (count_reg <= CountBits'(1));
    assign char_stall = in_valid_reg && !process;
    assign pop        = token_valid && !token_stall;
    assign token_valid = (count_reg != '0);
    assign token_word  = q_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_reg <= char_word;
        end
    end

    always_comb
    begin
        is_digit  = (b >= 8'h30) && (b <= 8'h39);
        is_alpha  = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
        is_space  = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
        is_ident  = is_alpha || is_digit || (b == CH_UNDERSCORE);
        is_hex    = is_digit || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
        is_bit    = (b == CH_ZERO) || (b == CH_ONE);
        // Bytes that are reported on their own right away: separators and other chars.
        is_single = !is_space && !is_ident && (b != CH_QUOTE) && (b != CH_DQUOTE);
        // The letter codes a..f and A..F all have low nibble 1..6.
        hex_val   = is_digit ? b[3:0] : b[3:0] + 4'd9;
    end

    // A pending token that the byte cannot extend is closed and the byte is lexed afresh.
    always_comb
    begin
        unique case (mode_reg)
            MODE_IDENT: close = !is_ident;
            MODE_NUM1:  close = !(is_digit || b == CH_DOT || b == CH_LOWER_X
                                  || b == CH_UPPER_X || b == CH_LOWER_B || b == CH_UPPER_B);
            MODE_DEC:   close = !(is_digit || b == CH_DOT);
            MODE_DOT:   close = !is_digit;
            MODE_FRAC:  close = !is_digit;
            MODE_HEX:   close = !is_hex;
            MODE_BIN:   close = !is_bit;
            default:    close = 1'b0;
        endcase
        restart = (mode_reg == MODE_IDLE) || close;
    end

    // Next state
    always_comb
    begin
        mode_next   = mode_reg;
        value_next  = value_reg;
        start_next  = start_reg;
        length_next = length_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        esc_next    = esc_reg;
        if (process)
        begin
            if (eot)
            begin
                mode_next   = MODE_IDLE;
                value_next  = '0;
                start_next  = '0;
                length_next = '0;
                line_next   = '0;
                pos_next    = '0;
                first_next  = '0;
                esc_next    = 1'b0;
            end
            else
            begin
                pos_next = sat_inc(pos_reg);
                if (restart)
                begin
                    mode_next = MODE_IDLE;
                    if (is_space)
                    begin
                        if (b == CH_NEWLINE)
                        begin
                            line_next = sat_inc(line_reg);
                        end
                    end
                    else
                    begin
                        start_next  = pos_reg;
                        length_next = pos_t'(1);
                        if (is_alpha || b == CH_UNDERSCORE)
                        begin
                            first_next = b;
                            mode_next  = MODE_IDENT;
                        end
                        else if (is_digit)
                        begin
                            value_next = {28'd0, b[3:0]};
                            mode_next  = MODE_NUM1;
                        end
                        else if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_CHOPEN;
                        end
                        else if (b == CH_DQUOTE)
                        begin
                            start_next  = sat_inc(pos_reg);
                            length_next = '0;
                            esc_next    = 1'b0;
                            mode_next   = MODE_STRING;
                        end
                    end
                end
                else
                begin
                    unique case (mode_reg) inside
                        MODE_IDENT, MODE_FRAC:
                        begin
                            length_next = sat_inc(length_reg);
                        end
                        MODE_NUM1, MODE_DEC:
                        begin
                            if (mode_reg == MODE_NUM1 && (b == CH_LOWER_X || b == CH_UPPER_X))
                            begin
                                value_next  = '0;
                                length_next = sat_inc(length_reg);
                                mode_next   = MODE_HEX;
                            end
                            else if (mode_reg == MODE_NUM1
                                     && (b == CH_LOWER_B || b == CH_UPPER_B))
                            begin
                                value_next  = '0;
                                length_next = sat_inc(length_reg);
                                mode_next   = MODE_BIN;
                            end
                            else if (is_digit)
                            begin
                                value_next  = (value_reg << 3) + (value_reg << 1)
                                              + {28'd0, b[3:0]};
                                length_next = sat_inc(length_reg);
                                mode_next   = MODE_DEC;
                            end
                            else
                            begin
                                mode_next = MODE_DOT;
                            end
                        end
                        MODE_DOT:
                        begin
                            length_next = sat_inc(sat_inc(length_reg));
                            mode_next   = MODE_FRAC;
                        end
                        MODE_HEX:
                        begin
                            value_next  = {value_reg[27:0], hex_val};
                            length_next = sat_inc(length_reg);
                        end
                        MODE_BIN:
                        begin
                            value_next  = {value_reg[30:0], b[0]};
                            length_next = sat_inc(length_reg);
                        end
                        MODE_CHOPEN:
                        begin
                            first_next  = b;
                            length_next = sat_inc(length_reg);
                            mode_next   = MODE_CHCLOSE;
                        end
                        MODE_CHCLOSE:
                        begin
                            mode_next = (b == CH_QUOTE) ? MODE_IDLE : MODE_ERROR;
                        end
                        MODE_STRING:
                        begin
                            if (esc_reg)
                            begin
                                esc_next    = 1'b0;
                                length_next = sat_inc(length_reg);
                            end
                            else if (b == CH_BACKSLASH)
                            begin
                                esc_next    = 1'b1;
                                length_next = sat_inc(length_reg);
                            end
                            else if (b == CH_DQUOTE)
                            begin
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                length_next = sat_inc(length_reg);
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_ERROR;
                        end
                    endcase
                end
            end
        end
    end

    // Tokens for the word in the input register
    always_comb
    begin
        logic [POSITION_BITS:0] dot_sum;
        pos_t                   dot_pos;
        logic [15:0]            line16;
        logic [15:0]            start16;
        logic [15:0]            len16;

        dot_sum = {1'b0, start_reg} + {1'b0, length_reg};
        dot_pos = dot_sum[POSITION_BITS] ? '1 : dot_sum[POSITION_BITS-1:0];
        line16  = rep16(line_reg);
        start16 = rep16(start_reg);
        len16   = rep16(length_reg);
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        res_count = '0;

        if (eot || close)
        begin
            unique case (mode_reg) inside
                MODE_IDENT:
                begin
                    res[res_count] = make_token(KIND_IDENT, {24'd0, first_reg},
                                                start16, len16, line16);
                    res_count = res_count + 2'd1;
                end
                MODE_NUM1, MODE_DEC, MODE_HEX, MODE_BIN, MODE_DOT:
                begin
                    res[res_count] = make_token(KIND_NUMBER, value_reg, start16, len16, line16);
                    res_count = res_count + 2'd1;
                    if (mode_reg == MODE_DOT)
                    begin
                        // The dot did not begin a fraction: it is a char of its own.
                        res[res_count] = make_token(KIND_CHAR, {24'd0, CH_DOT},
                                                    rep16(dot_pos), 16'd1, line16);
                        res_count = res_count + 2'd1;
                    end
                end
                MODE_FRAC:
                begin
                    res[res_count] = make_token(KIND_FLOAT, value_reg, start16, len16, line16);
                    res_count = res_count + 2'd1;
                end
                MODE_STRING:
                begin
                    res[res_count] = make_token(KIND_STRING, {24'd0, CH_DQUOTE},
                                                start16, len16, line16);
                    res_count = res_count + 2'd1;
                end
                MODE_CHOPEN, MODE_CHCLOSE:
                begin
                    res[res_count] = make_token(KIND_ERROR, 32'd0, start16, len16, line16);
                    res_count = res_count + 2'd1;
                end
                default:
                begin
                end
            endcase
        end

        if (eot)
        begin
            res[res_count] = make_token(KIND_END, 32'd0, rep16(pos_reg), 16'd0, line16);
            res_count = res_count + 2'd1;
        end
        else if (restart)
        begin
            if (is_single)
            begin
                res[res_count] = make_token((b == CH_COMMA || b == CH_SEMICOLON)
                                            ? KIND_SEP : KIND_CHAR,
                                            {24'd0, b}, rep16(pos_reg), 16'd1, line16);
                res_count = res_count + 2'd1;
            end
        end
        else if (mode_reg == MODE_CHCLOSE)
        begin
            if (b == CH_QUOTE)
            begin
                res[res_count] = make_token(KIND_NUMBER, {24'd0, first_reg}, start16,
                                            rep16(sat_inc(length_reg)), line16);
            end
            else
            begin
                res[res_count] = make_token(KIND_ERROR, 32'd0, start16, len16, line16);
            end
            res_count = res_count + 2'd1;
        end
        else if (mode_reg == MODE_STRING && !esc_reg && b == CH_DQUOTE)
        begin
            res[res_count] = make_token(KIND_STRING, {24'd0, CH_DQUOTE},
                                        start16, len16, line16);
            res_count = res_count + 2'd1;
        end

        if (res_count != 2'd0)
        begin
            res[res_count - 2'd1].last_in_run = 1'b1;
        end
    end

    // Result queue: drop the head on a take, then append this word's tokens.
    always_comb
    begin
        token_word_t              shifted [QUEUE_DEPTH];
        logic [CountBits-1:0]     base;
        logic [CountBits-1:0]     k;

        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            shifted[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                shifted[i] = q_reg[i + 1];
            end
        end
        base = count_reg - CountBits'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            k = CountBits'(i) - base;
            q_next[i] = shifted[i];
            if (process && (CountBits'(i) >= base) && (k < CountBits'(res_count)))
            begin
                q_next[i] = res[k[1:0]];
            end
        end
        count_next = base + (process ? CountBits'(res_count) : '0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mode_reg   <= MODE_IDLE;
            value_reg  <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            line_reg   <= '0;
            pos_reg    <= '0;
            first_reg  <= '0;
            esc_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            mode_reg   <= mode_next;
            value_reg  <= value_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            esc_reg    <= esc_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountBits'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && eot) |=> (mode_reg == MODE_IDLE) && (pos_reg == '0) && (line_reg == '0))
        else $error("end of text did not return the lexer to its start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && eot) |=> (count_reg != '0))
        else $error("end of text gave no token");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR && !(process && eot)) |=> (mode_reg == MODE_ERROR))
        else $error("error mode left before end of text");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(process && eot) |=> (line_reg >= $past(line_reg)))
        else $error("line count went backward");

endmodule

// ===== bench/lexer_watch.sv =====
`timescale 1ns / 1ps

module lexer_watch
    import csl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_stall,
    input  char_word_t  char_word,
    input  logic        token_valid,
    input  logic        token_stall,
    input  token_word_t token_word,
    output int          mismatches,
    output int          tokens_due
);

    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    mode_t       mode;
    logic [31:0] number_value;
    logic [15:0] token_begin;
    logic [15:0] token_len;
    logic [15:0] line_count;
    logic [15:0] offset;
    logic [7:0]  lead_char;
    logic        escaped;
    int          error_total;
    token_word_t step_tokens[$];
    token_word_t expected_tokens[$];

    function automatic logic [15:0] sat_bump(input logic [15:0] x);
        return (x == POS_LIMIT) ? x : x + 16'd1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic add_token(input kind_t kind, input logic [31:0] value,
                             input logic [15:0] at, input logic [15:0] len);
        token_word_t t;
        t.token_kind   = kind;
        t.token_value  = value;
        t.token_start  = at;
        t.token_length = len;
        t.line_number  = line_count;
        t.last_in_run  = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic flush_token();
        logic [16:0] dot_at;
        case (mode)
            MODE_IDENT:
                add_token(KIND_IDENT, {24'd0, lead_char}, token_begin, token_len);
            MODE_NUM1, MODE_DEC, MODE_HEX, MODE_BIN:
                add_token(KIND_NUMBER, number_value, token_begin, token_len);
            MODE_DOT:
            begin
                // The dot that no digit followed is reported on its own after the number.
                add_token(KIND_NUMBER, number_value, token_begin, token_len);
                dot_at = {1'b0, token_begin} + {1'b0, token_len};
                add_token(KIND_CHAR, {24'd0, CH_DOT},
                          dot_at[16] ? POS_LIMIT : dot_at[15:0], 16'd1);
            end
            MODE_FRAC:
                add_token(KIND_FLOAT, number_value, token_begin, token_len);
            MODE_STRING:
                add_token(KIND_STRING, {24'd0, CH_DQUOTE}, token_begin, token_len);
            MODE_CHOPEN, MODE_CHCLOSE:
                add_token(KIND_ERROR, 32'd0, token_begin, token_len);
            default:
            begin
            end
        endcase
        mode = MODE_IDLE;
    endtask

    task automatic begin_token(input logic [7:0] c);
        if (is_blank(c))
        begin
            if (c == CH_NEWLINE)
                line_count = sat_bump(line_count);
        end
        else
        begin
            token_begin = offset;
            token_len   = 16'd1;
            if (is_letter(c) || c == CH_UNDERSCORE)
            begin
                lead_char = c;
                mode      = MODE_IDENT;
            end
            else if (is_digit(c))
            begin
                number_value = {28'd0, c[3:0]};
                mode         = MODE_NUM1;
            end
            else if (c == CH_QUOTE)
                mode = MODE_CHOPEN;
            else if (c == CH_DQUOTE)
            begin
                // A string starts after its opening quote.
                token_begin = sat_bump(offset);
                token_len   = 16'd0;
                escaped     = 1'b0;
                mode        = MODE_STRING;
            end
            else if (c == CH_COMMA || c == CH_SEMICOLON)
                add_token(KIND_SEP, {24'd0, c}, offset, 16'd1);
            else
                add_token(KIND_CHAR, {24'd0, c}, offset, 16'd1);
        end
    endtask

    task automatic restart(input logic [7:0] c);
        flush_token();
        begin_token(c);
    endtask

    task automatic lex_byte(input logic [7:0] c);
        logic [3:0] nibble;
        case (mode)
            MODE_IDLE:
                begin_token(c);
            MODE_IDENT:
                if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE)
                    token_len = sat_bump(token_len);
                else
                    restart(c);
            MODE_NUM1, MODE_DEC:
            begin
                if (mode == MODE_NUM1 && (c == CH_LOWER_X || c == CH_UPPER_X))
                begin
                    number_value = 32'd0;
                    token_len    = sat_bump(token_len);
                    mode         = MODE_HEX;
                end
                else if (mode == MODE_NUM1 && (c == CH_LOWER_B || c == CH_UPPER_B))
                begin
                    number_value = 32'd0;
                    token_len    = sat_bump(token_len);
                    mode         = MODE_BIN;
                end
                else if (is_digit(c))
                begin
                    number_value = number_value * 32'd10 + {28'd0, c[3:0]};
                    token_len    = sat_bump(token_len);
                    mode         = MODE_DEC;
                end
                else if (c == CH_DOT)
                    mode = MODE_DOT;
                else
                    restart(c);
            end
            MODE_DOT:
                if (is_digit(c))
                begin
                    token_len = sat_bump(sat_bump(token_len));
                    mode      = MODE_FRAC;
                end
                else
                    restart(c);
            MODE_FRAC:
                if (is_digit(c))
                    token_len = sat_bump(token_len);
                else
                    restart(c);
            MODE_HEX:
                if (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                begin
                    // Letters a-f and A-F both carry 1..6 in the low nibble.
                    nibble       = is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
                    number_value = {number_value[27:0], nibble};
                    token_len    = sat_bump(token_len);
                end
                else
                    restart(c);
            MODE_BIN:
                if (c == CH_ZERO || c == CH_ONE)
                begin
                    number_value = {number_value[30:0], c[0]};
                    token_len    = sat_bump(token_len);
                end
                else
                    restart(c);
            MODE_CHOPEN:
            begin
                lead_char = c;
                token_len = sat_bump(token_len);
                mode      = MODE_CHCLOSE;
            end
            MODE_CHCLOSE:
                if (c == CH_QUOTE)
                begin
                    add_token(KIND_NUMBER, {24'd0, lead_char}, token_begin,
                              sat_bump(token_len));
                    mode = MODE_IDLE;
                end
                else
                begin
                    add_token(KIND_ERROR, 32'd0, token_begin, token_len);
                    mode = MODE_ERROR;
                end
            MODE_STRING:
                if (escaped)
                begin
                    escaped   = 1'b0;
                    token_len = sat_bump(token_len);
                end
                else if (c == CH_BACKSLASH)
                begin
                    escaped   = 1'b1;
                    token_len = sat_bump(token_len);
                end
                else if (c == CH_DQUOTE)
                begin
                    add_token(KIND_STRING, {24'd0, CH_DQUOTE}, token_begin, token_len);
                    mode = MODE_IDLE;
                end
                else
                    token_len = sat_bump(token_len);
            default:
                mode = MODE_ERROR;
        endcase
    endtask

    task automatic clear_lexer();
        mode         = MODE_IDLE;
        number_value = 32'd0;
        token_begin  = 16'd0;
        token_len    = 16'd0;
        line_count   = 16'd0;
        offset       = 16'd0;
        lead_char    = 8'd0;
        escaped      = 1'b0;
    endtask

    task automatic predict_tokens(input char_word_t w);
        token_word_t t;
        if (w.end_of_text)
        begin
            flush_token();
            add_token(KIND_END, 32'd0, offset, 16'd0);
            clear_lexer();
        end
        else
        begin
            lex_byte(w.text_byte);
            offset = sat_bump(offset);
        end
        foreach (step_tokens[i])
        begin
            t             = step_tokens[i];
            t.last_in_run = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
        step_tokens.delete();
    endtask

    task automatic check_token(input token_word_t got);
        token_word_t want;
        if (expected_tokens.size() == 0)
        begin
            error_total++;
            $display("%0t unexpected token: expected none, actual kind %0d value %h",
                     $time, got.token_kind, got.token_value,
                     " start %0d length %0d line %0d last %b",
                     got.token_start, got.token_length, got.line_number, got.last_in_run);
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.token_value !== want.token_value ||
                got.token_start !== want.token_start ||
                got.token_length !== want.token_length ||
                got.line_number !== want.line_number || got.last_in_run !== want.last_in_run)
            begin
                error_total++;
                $display("%0t token mismatch: expected %0d/%h/%0d/%0d/%0d/%b",
                         $time, want.token_kind, want.token_value, want.token_start,
                         want.token_length, want.line_number, want.last_in_run,
                         ", actual %0d/%h/%0d/%0d/%0d/%b",
                         got.token_kind, got.token_value, got.token_start,
                         got.token_length, got.line_number, got.last_in_run);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            step_tokens.delete();
            expected_tokens.delete();
            error_total = 0;
            mismatches <= 0;
            tokens_due <= 0;
        end
        else
        begin
            if (token_valid && !token_stall)
                check_token(token_word);
            if (char_valid && !char_stall)
                predict_tokens(char_word);
            mismatches <= error_total;
            tokens_due <= expected_tokens.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import csl_pkg::*;

    localparam int TEXT_WORDS  = 190;
    localparam int HOLD_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_stall;
    char_word_t  char_word;
    logic        token_valid;
    logic        token_stall;
    token_word_t token_word;
    int          mismatches;
    int          tokens_due;

    int          burst_left   = 0;
    int          text_words   = 0;
    bit          hold_off_due = 1'b0;
    logic [7:0]  chunk[$];
    string       opening_text = "_,0X;1b1 2.5\n3.,'q'\"\\\"";

    character_stream_lexer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    lexer_watch watch
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word),
        .mismatches  (mismatches),
        .tokens_due  (tokens_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Token side: stall phases of random density, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        int phase_left;
        int stall_pct;
        bit hold_done;
        hold_left   = 0;
        phase_left  = 0;
        stall_pct   = 0;
        hold_done   = 1'b0;
        token_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                token_stall <= 1'b1;
            end
            else if (hold_off_due && !hold_done)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                token_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(5, 40);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                phase_left--;
                token_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_valid            <= 1'b1;
        char_word.text_byte   <= b;
        char_word.end_of_text <= eot;
        do
            @(posedge clk);
        while (char_stall);
    endtask

    task automatic send_chunk();
        foreach (chunk[i])
            send_word(chunk[i], 1'b0);
        text_words += chunk.size();
        chunk.delete();
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(25));
        return $urandom_range(1) ? c : c - 8'h20;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_hex_digit();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return CH_ZERO + 8'(r);
        else if (r < 16)
            return 8'h61 + 8'(r - 10);
        else
            return 8'h41 + 8'(r - 16);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0, 1: return " ";
            2: return CH_NEWLINE;
            default: return 8'd9 + 8'($urandom_range(4));
        endcase
    endfunction

    // Builds the text of one token; some shapes are left broken and must end the text.
    task automatic compose_token(output bit must_end, output int junk);
        int         n;
        logic [7:0] c;
        must_end = 1'b0;
        junk     = 0;
        case ($urandom_range(11))
            0, 1:
            begin
                chunk.push_back($urandom_range(3) == 0 ? CH_UNDERSCORE : pick_letter());
                n = $urandom_range(0, 6);
                repeat (n)
                    case ($urandom_range(3))
                        0: chunk.push_back(pick_digit());
                        1: chunk.push_back(CH_UNDERSCORE);
                        default: chunk.push_back(pick_letter());
                    endcase
            end
            2:
            begin
                n = $urandom_range(1, 12);
                repeat (n) chunk.push_back(pick_digit());
            end
            3:
            begin
                chunk.push_back(pick_digit());
                chunk.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
                n = $urandom_range(0, 10);
                repeat (n) chunk.push_back(pick_hex_digit());
            end
            4:
            begin
                chunk.push_back(pick_digit());
                chunk.push_back($urandom_range(1) ? CH_LOWER_B : CH_UPPER_B);
                n = $urandom_range(0, 34);
                repeat (n) chunk.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
            end
            5:
            begin
                n = $urandom_range(1, 3);
                repeat (n) chunk.push_back(pick_digit());
                chunk.push_back(CH_DOT);
                if ($urandom_range(3) != 0)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) chunk.push_back(pick_digit());
                end
            end
            6:
            begin
                chunk.push_back(CH_QUOTE);
                chunk.push_back(8'($urandom_range(255)));
                chunk.push_back(CH_QUOTE);
            end
            7:
            begin
                chunk.push_back(CH_DQUOTE);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    c = 8'($urandom_range(255));
                    if (c == CH_DQUOTE || c == CH_BACKSLASH || $urandom_range(7) == 0)
                        chunk.push_back(CH_BACKSLASH);
                    chunk.push_back(c);
                end
                if ($urandom_range(5) == 0)
                    must_end = 1'b1;
                else
                    chunk.push_back(CH_DQUOTE);
            end
            8:
                chunk.push_back($urandom_range(1) ? CH_COMMA : CH_SEMICOLON);
            9:
                case ($urandom_range(4))
                    0: chunk.push_back(8'h00);
                    1: chunk.push_back(8'hFF);
                    2: chunk.push_back(8'h80 + 8'($urandom_range(127)));
                    3: chunk.push_back(CH_DOT);
                    default: chunk.push_back(8'h21 + 8'($urandom_range(14)));
                endcase
            10:
            begin
                // Character literal with no closing quote, or one cut off by the end.
                chunk.push_back(CH_QUOTE);
                if ($urandom_range(2) != 0)
                begin
                    chunk.push_back(8'($urandom_range(255)));
                    chunk.push_back(pick_letter());
                    junk = $urandom_range(0, 3);
                end
                must_end = 1'b1;
            end
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n) chunk.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    initial
    begin
        bit must_end;
        int junk;
        int tokens_to_end;
        bit held;
        bit paused;
        held                  = 1'b0;
        paused                = 1'b0;
        rst_n                 <= 1'b0;
        char_valid            <= 1'b0;
        char_word.text_byte   <= 8'd0;
        char_word.end_of_text <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every token kind but the error, a dot with no digit after it, an empty prefix,
        // a newline, and a string cut off by the end.
        for (int i = 0; i < opening_text.len(); i++)
            chunk.push_back(opening_text[i]);
        send_chunk();
        send_word(8'h00, 1'b1);
        // Byte zero, top byte, a bad literal, then the end after the error.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word("a", 1'b0);
        send_word("b", 1'b0);
        send_word(8'hFF, 1'b1);
        // End inside a character literal.
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h5A, 1'b1);
        drain();

        text_words    = 0;
        tokens_to_end = $urandom_range(2, 12);
        while (text_words < TEXT_WORDS)
        begin
            compose_token(must_end, junk);
            if (!must_end && $urandom_range(9) < 7)
                repeat ($urandom_range(1, 2)) chunk.push_back(pick_blank());
            send_chunk();
            // Bytes after an error are ignored and do not count as text.
            repeat (junk) send_word(8'($urandom_range(255)), 1'b0);
            tokens_to_end--;
            if (must_end || tokens_to_end <= 0)
            begin
                send_word(8'($urandom_range(255)), 1'b1);
                text_words++;
                tokens_to_end = $urandom_range(2, 12);
            end
            if (!held && text_words > 40)
            begin
                hold_off_due = 1'b1;
                held         = 1'b1;
            end
            if (!paused && text_words > 130)
            begin
                drain();
                paused = 1'b1;
            end
        end
        send_word(8'($urandom_range(255)), 1'b1);
        drain();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && tokens_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
